// ===== rtl/core/dlr_pkg.sv =====
// shared types and constants for the dda line rasterizer
`timescale 1ns / 1ps
package dlr_pkg;

	// port width of every coordinate field
	localparam int PT_W = 6;

	// default configuration of the design
	localparam int COORD_BITS_DEF = 6;
	localparam int FRAC_BITS_DEF = 16;

	// commands from controller to datapath
	typedef struct packed {
		logic load;
		logic div_step;
		logic emit_point;
		logic emit_last;
	} dlr_cmd_t;

	// status from datapath to controller
	typedef struct packed {
		logic div_last;
		logic steps_zero;
		logic steps_one;
	} dlr_sts_t;

endpackage

// ===== rtl/core/dlr_dp.sv =====
// datapath: deltas, bit-serial increment division, accumulators, output register
`timescale 1ns / 1ps
module dlr_dp #(
	parameter int COORD_BITS = dlr_pkg::COORD_BITS_DEF,
	parameter int FRAC_BITS  = dlr_pkg::FRAC_BITS_DEF
) (
	input  logic                     clk,
	input  dlr_pkg::dlr_cmd_t        cmd,
	output dlr_pkg::dlr_sts_t        sts,
	input  logic [dlr_pkg::PT_W-1:0] start_x,
	input  logic [dlr_pkg::PT_W-1:0] start_y,
	input  logic [dlr_pkg::PT_W-1:0] end_x,
	input  logic [dlr_pkg::PT_W-1:0] end_y,
	output logic [dlr_pkg::PT_W-1:0] point_x,
	output logic [dlr_pkg::PT_W-1:0] point_y,
	output logic                     last_point
);
	import dlr_pkg::*;

	localparam int CB    = COORD_BITS;
	localparam int ACC_W = COORD_BITS + FRAC_BITS + 1;
	localparam int INC_W = FRAC_BITS + 2;
	localparam int CNT_W = $clog2(FRAC_BITS + 1);

	// used coordinate bits of the command
	logic [CB-1:0] sx, sy, ex, ey;
	assign sx = start_x[CB-1:0];
	assign sy = start_y[CB-1:0];
	assign ex = end_x[CB-1:0];
	assign ey = end_y[CB-1:0];

	// signed deltas, magnitudes and step count
	logic signed [CB:0] dx, dy;
	logic [CB-1:0]      adx, ady, steps;
	assign dx    = $signed({1'b0, ex}) - $signed({1'b0, sx});
	assign dy    = $signed({1'b0, ey}) - $signed({1'b0, sy});
	assign adx   = dx[CB] ? CB'(-dx) : dx[CB-1:0];
	assign ady   = dy[CB] ? CB'(-dy) : dy[CB-1:0];
	assign steps = (adx > ady) ? adx : ady;

	// registers
	logic signed [ACC_W-1:0] acc_x_q, acc_y_q;
	logic [FRAC_BITS:0]      qx_q, qy_q;
	logic [CB:0]             rx_q, ry_q;
	logic [CB-1:0]           steps_q, steps_left_q;
	logic                    neg_x_q, neg_y_q;
	logic [CB-1:0]           end_x_q, end_y_q;
	logic [CNT_W-1:0]        cnt_q;
	logic [PT_W-1:0]         point_x_q, point_y_q;
	logic                    last_q;

	// one restoring division step per axis
	logic        gex, gey;
	logic [CB:0] rx_sub, ry_sub;
	assign gex    = rx_q >= {1'b0, steps_q};
	assign gey    = ry_q >= {1'b0, steps_q};
	assign rx_sub = gex ? rx_q - {1'b0, steps_q} : rx_q;
	assign ry_sub = gey ? ry_q - {1'b0, steps_q} : ry_q;

	// signed increments from quotient magnitude and delta sign
	logic signed [INC_W-1:0] inc_x, inc_y;
	assign inc_x = neg_x_q ? -$signed({1'b0, qx_q}) : $signed({1'b0, qx_q});
	assign inc_y = neg_y_q ? -$signed({1'b0, qy_q}) : $signed({1'b0, qy_q});

	// ceiling of the accumulators, negative clamps to zero
	localparam logic [ACC_W-1:0] ROUND = {{(CB + 1){1'b0}}, {FRAC_BITS{1'b1}}};
	logic [ACC_W-1:0] cx_sum, cy_sum;
	logic [CB-1:0]    ceil_x, ceil_y;
	assign cx_sum = $unsigned(acc_x_q) + ROUND;
	assign cy_sum = $unsigned(acc_y_q) + ROUND;
	assign ceil_x = acc_x_q[ACC_W-1] ? '0 : cx_sum[FRAC_BITS+CB-1:FRAC_BITS];
	assign ceil_y = acc_y_q[ACC_W-1] ? '0 : cy_sum[FRAC_BITS+CB-1:FRAC_BITS];

	// command capture, division and walk
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			acc_x_q      <= $signed({1'b0, sx, {FRAC_BITS{1'b0}}});
			acc_y_q      <= $signed({1'b0, sy, {FRAC_BITS{1'b0}}});
			rx_q         <= {1'b0, adx};
			ry_q         <= {1'b0, ady};
			qx_q         <= '0;
			qy_q         <= '0;
			steps_q      <= steps;
			steps_left_q <= steps;
			neg_x_q      <= dx[CB];
			neg_y_q      <= dy[CB];
			end_x_q      <= ex;
			end_y_q      <= ey;
			cnt_q        <= CNT_W'(FRAC_BITS);
		end else if (cmd.div_step) begin
			rx_q  <= {rx_sub[CB-1:0], 1'b0};
			ry_q  <= {ry_sub[CB-1:0], 1'b0};
			qx_q  <= {qx_q[FRAC_BITS-1:0], gex};
			qy_q  <= {qy_q[FRAC_BITS-1:0], gey};
			cnt_q <= cnt_q - CNT_W'(1);
		end else if (cmd.emit_point) begin
			acc_x_q      <= acc_x_q + ACC_W'(inc_x);
			acc_y_q      <= acc_y_q + ACC_W'(inc_y);
			steps_left_q <= steps_left_q - CB'(1);
		end
	end

	// output register
	always_ff @(posedge clk) begin
		if (cmd.emit_point) begin
			point_x_q <= PT_W'(ceil_x);
			point_y_q <= PT_W'(ceil_y);
			last_q    <= 1'b0;
		end else if (cmd.emit_last) begin
			point_x_q <= PT_W'(end_x_q);
			point_y_q <= PT_W'(end_y_q);
			last_q    <= 1'b1;
		end
	end

	assign point_x    = point_x_q;
	assign point_y    = point_y_q;
	assign last_point = last_q;

	// status back to the controller
	assign sts.div_last   = (cnt_q == '0);
	assign sts.steps_zero = (steps_left_q == '0);
	assign sts.steps_one  = (steps_left_q == CB'(1));

endmodule

// ===== rtl/core/dlr_ctrl.sv =====
// controller: command sequencing and output handshake
`timescale 1ns / 1ps
module dlr_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cmd_valid,
	output logic              cmd_ready,
	output logic              point_valid,
	input  logic              point_ready,
	output dlr_pkg::dlr_cmd_t cmd,
	input  dlr_pkg::dlr_sts_t sts
);
	import dlr_pkg::*;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DIV,
		ST_EMIT,
		ST_LAST
	} state_t;

	state_t state_q;
	logic   point_valid_q;
	logic   slot_free;

	// output register can take a new point
	assign slot_free = !point_valid_q || point_ready;

	// commands
	assign cmd_ready      = (state_q == ST_IDLE);
	assign cmd.load       = (state_q == ST_IDLE) && cmd_valid;
	assign cmd.div_step   = (state_q == ST_DIV);
	assign cmd.emit_point = (state_q == ST_EMIT) && slot_free;
	assign cmd.emit_last  = (state_q == ST_LAST) && slot_free;
	assign point_valid    = point_valid_q;

	// state and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			point_valid_q <= 1'b0;
		end else begin
			if (cmd.emit_point || cmd.emit_last) begin
				point_valid_q <= 1'b1;
			end else if (point_ready) begin
				point_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (cmd_valid) begin
						state_q <= ST_DIV;
					end
				end
				ST_DIV: begin
					if (sts.div_last) begin
						state_q <= sts.steps_zero ? ST_LAST : ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (slot_free && sts.steps_one) begin
						state_q <= ST_LAST;
					end
				end
				ST_LAST: begin
					if (slot_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// a point never overwrites one that is still waiting
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.emit_point || cmd.emit_last) |-> slot_free)
		else $error("output register overwritten");

	// an accumulated point is only emitted while steps remain
	a_steps_left: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit_point |-> !sts.steps_zero)
		else $error("point emitted with no steps left");

	// the end point closes the transaction and frees the input side
	a_last_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit_last |=> (cmd_ready && point_valid))
		else $error("controller not idle after end point");

	// a new command is taken only when no walk is under way
	a_load_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |-> !(cmd.div_step || cmd.emit_point || cmd.emit_last))
		else $error("command loaded during a walk");

endmodule

// ===== rtl/core/dda_line_rasterizer_top.sv =====
// Top level of the dda line rasterizer: controller plus datapath.
// Sequence: the command is taken in the idle state, then bit-serial division forms the increments,
// then one point per cycle goes into the output register while the output slot is free.
// Commands: a new command is taken only once the end point of the last one has been emitted;
// the time a command takes is set by the division and the walk of steps = max(|dx|,|dy|).
// Reset: arst_n asynchronously clears the controller; the block then idles, ready.
`timescale 1ns / 1ps
module dda_line_rasterizer_top #(
	parameter int COORD_BITS = dlr_pkg::COORD_BITS_DEF,
	parameter int FRAC_BITS  = dlr_pkg::FRAC_BITS_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cmd_valid,
	output logic                     cmd_ready,
	input  logic [dlr_pkg::PT_W-1:0] start_x,
	input  logic [dlr_pkg::PT_W-1:0] start_y,
	input  logic [dlr_pkg::PT_W-1:0] end_x,
	input  logic [dlr_pkg::PT_W-1:0] end_y,
	output logic                     point_valid,
	input  logic                     point_ready,
	output logic [dlr_pkg::PT_W-1:0] point_x,
	output logic [dlr_pkg::PT_W-1:0] point_y,
	output logic                     last_point
);
	import dlr_pkg::*;

	dlr_cmd_t cmd;
	dlr_sts_t sts;

	// sequencing
	dlr_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd_valid   (cmd_valid),
		.cmd_ready   (cmd_ready),
		.point_valid (point_valid),
		.point_ready (point_ready),
		.cmd         (cmd),
		.sts         (sts)
	);

	// arithmetic
	dlr_dp #(
		.COORD_BITS (COORD_BITS),
		.FRAC_BITS  (FRAC_BITS)
	) u_dp (
		.clk        (clk),
		.cmd        (cmd),
		.sts        (sts),
		.start_x    (start_x),
		.start_y    (start_y),
		.end_x      (end_x),
		.end_y      (end_y),
		.point_x    (point_x),
		.point_y    (point_y),
		.last_point (last_point)
	);

endmodule
